[hw/rtl/ows_pkg.sv]
// Shared types, codes and helpers of the 1-Wire ROM search engine.
`timescale 1ns / 1ps
`default_nettype none

package ows_pkg;

  localparam int unsigned CMD_DEPTH = 2;
  localparam int unsigned RES_DEPTH = 2;

  localparam int unsigned ROM_W = 64;
  localparam int unsigned POS_W = 7;
  localparam int unsigned FAM_W = 4;
  localparam int unsigned CRC_W = 8;

  localparam logic [POS_W-1:0] BIT_END      = POS_W'(65);
  localparam logic [POS_W-1:0] FAMILY_LIMIT = POS_W'(9);
  localparam logic [CRC_W-1:0] CRC_TAP      = 8'h18;

  localparam logic [1:0] CMD_BEGIN = 2'd0;
  localparam logic [1:0] CMD_PAIR  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_BEGIN,
    OP_PAIR_ONES,
    OP_PAIR_DIFF,
    OP_PAIR_SAME,
    OP_CLEAR
  } op_e;

  typedef enum logic [1:0] {
    ST_CONTINUE   = 2'd0,
    ST_NOT_FOUND  = 2'd1,
    ST_FOUND      = 2'd2,
    ST_FOUND_LAST = 2'd3
  } status_e;

  typedef struct packed {
    op_e  op;
    logic presence;
    logic id_bit;
  } cmd_word_t;

  typedef struct packed {
    status_e          status;
    logic             direction;
    logic             done;
    logic [ROM_W-1:0] rom_code;
    logic [FAM_W-1:0] family_disc;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_bit(input logic [CRC_W-1:0] crc,
                                               input logic bit_in);
    logic             fb;
    logic [CRC_W-1:0] c;
    fb = crc[0] ^ bit_in;
    c  = fb ? (crc ^ CRC_TAP) : crc;
    c  = {fb, c[CRC_W-1:1]};
    return c;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/ows_fifo.sv]
// Small first-in first-out queue of packed words.
`timescale 1ns / 1ps
`default_nettype none

module ows_fifo #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [Width-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [Width-1:0]      data_o,
  output logic                  empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue count above depth");

  a_cnt_up: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not advance on write");

  a_cnt_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !do_push && do_pop |=> cnt_q == $past(cnt_q) - 1'b1)
    else $error("queue count did not drop on read");

endmodule

`default_nettype wire

[hw/rtl/ows_front.sv]
// Front end: decodes incoming words into engine operations and queues them.
`timescale 1ns / 1ps
`default_nettype none

module ows_front #(
  parameter int unsigned Depth = ows_pkg::CMD_DEPTH
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push,
  output logic               full,
  input  wire logic [1:0]    cmd_i,
  input  wire logic          presence_ok_i,
  input  wire logic          id_bit_i,
  input  wire logic          complement_bit_i,
  output ows_pkg::cmd_word_t word_o,
  output logic               valid_o,
  input  wire logic          take_i
);

  import ows_pkg::*;

  cmd_word_t word_in;
  logic      q_empty;

  always_comb begin
    word_in.presence = presence_ok_i;
    word_in.id_bit   = id_bit_i;
    case (cmd_i)
      CMD_BEGIN: word_in.op = OP_BEGIN;
      CMD_PAIR: begin
        if (id_bit_i && complement_bit_i) begin
          word_in.op = OP_PAIR_ONES;
        end else if (id_bit_i != complement_bit_i) begin
          word_in.op = OP_PAIR_DIFF;
        end else begin
          word_in.op = OP_PAIR_SAME;
        end
      end
      CMD_CLEAR: word_in.op = OP_CLEAR;
      default:   word_in.op = OP_NOP;
    endcase
  end

  ows_fifo #(
    .Width ($bits(cmd_word_t)),
    .Depth (Depth)
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (word_in),
    .full_o  (full),
    .pop_i   (take_i),
    .data_o  (word_o),
    .empty_o (q_empty)
  );

  assign valid_o = !q_empty;

endmodule

`default_nettype wire

[hw/rtl/ows_engine.sv]
// Back end: search state, direction choice, ROM code and CRC update per word.
`timescale 1ns / 1ps
`default_nettype none

module ows_engine (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ows_pkg::cmd_word_t  word_i,
  input  wire logic                valid_i,
  output logic                     take_o,
  input  wire logic                res_full_i,
  output logic                     res_push_o,
  output ows_pkg::result_t         res_o
);

  import ows_pkg::*;

  logic [ROM_W-1:0] rom_q, rom_d;
  logic [POS_W-1:0] ld_q, ld_d;
  logic [FAM_W-1:0] lfd_q, lfd_d;
  logic             lds_q, lds_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [POS_W-1:0] lzp_q, lzp_d;
  logic [CRC_W-1:0] crc_q, crc_d;
  logic             active_q, active_d;

  logic                     fire;
  logic                     dir;
  logic [$clog2(ROM_W)-1:0] idx;

  assign fire       = valid_i && !res_full_i;
  assign take_o     = fire;
  assign res_push_o = fire;
  assign idx        = pos_q[$clog2(ROM_W)-1:0] - 1'b1;

  always_comb begin
    rom_d    = rom_q;
    ld_d     = ld_q;
    lfd_d    = lfd_q;
    lds_d    = lds_q;
    pos_d    = pos_q;
    lzp_d    = lzp_q;
    crc_d    = crc_q;
    active_d = active_q;
    dir      = 1'b0;
    res_o.status = ST_CONTINUE;
    res_o.done   = 1'b0;
    if (fire) begin
      case (word_i.op)
        OP_BEGIN: begin
          if (lds_q || !word_i.presence) begin
            ld_d         = '0;
            lds_d        = 1'b0;
            lfd_d        = '0;
            active_d     = 1'b0;
            res_o.status = ST_NOT_FOUND;
            res_o.done   = 1'b1;
          end else begin
            pos_d    = POS_W'(1);
            lzp_d    = '0;
            crc_d    = '0;
            active_d = 1'b1;
          end
        end
        OP_PAIR_ONES, OP_PAIR_DIFF, OP_PAIR_SAME: begin
          if (!active_q) begin
            res_o.status = ST_NOT_FOUND;
            res_o.done   = 1'b1;
          end else if (word_i.op == OP_PAIR_ONES) begin
            ld_d         = '0;
            lds_d        = 1'b0;
            lfd_d        = '0;
            active_d     = 1'b0;
            res_o.status = ST_NOT_FOUND;
            res_o.done   = 1'b1;
          end else begin
            if (word_i.op == OP_PAIR_DIFF) begin
              dir = word_i.id_bit;
            end else begin
              if (pos_q < ld_q) begin
                dir = rom_q[idx];
              end else begin
                dir = (pos_q == ld_q);
              end
              if (!dir) begin
                lzp_d = pos_q;
                if (pos_q < FAMILY_LIMIT) begin
                  lfd_d = pos_q[FAM_W-1:0];
                end
              end
            end
            rom_d[idx] = dir;
            crc_d      = crc_bit(crc_q, dir);
            pos_d      = pos_q + 1'b1;
            if (pos_d >= BIT_END) begin
              active_d   = 1'b0;
              res_o.done = 1'b1;
              if (crc_d == '0 && rom_d[7:0] != 8'h00) begin
                ld_d = lzp_d;
                if (lzp_d == '0) begin
                  lds_d        = 1'b1;
                  res_o.status = ST_FOUND_LAST;
                end else begin
                  res_o.status = ST_FOUND;
                end
              end else begin
                ld_d         = '0;
                lds_d        = 1'b0;
                lfd_d        = '0;
                res_o.status = ST_NOT_FOUND;
              end
            end
          end
        end
        OP_CLEAR: begin
          rom_d        = '0;
          ld_d         = '0;
          lfd_d        = '0;
          lds_d        = 1'b0;
          pos_d        = POS_W'(1);
          lzp_d        = '0;
          crc_d        = '0;
          active_d     = 1'b0;
          res_o.status = ST_NOT_FOUND;
          res_o.done   = 1'b1;
        end
        default: begin
          res_o.status = ST_CONTINUE;
        end
      endcase
    end
    res_o.direction   = dir;
    res_o.rom_code    = rom_d;
    res_o.family_disc = lfd_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q    <= '0;
      ld_q     <= '0;
      lfd_q    <= '0;
      lds_q    <= 1'b0;
      pos_q    <= POS_W'(1);
      lzp_q    <= '0;
      crc_q    <= '0;
      active_q <= 1'b0;
    end else begin
      rom_q    <= rom_d;
      ld_q     <= ld_d;
      lfd_q    <= lfd_d;
      lds_q    <= lds_d;
      pos_q    <= pos_d;
      lzp_q    <= lzp_d;
      crc_q    <= crc_d;
      active_q <= active_d;
    end
  end

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && word_i.op == OP_CLEAR |=> pos_q == POS_W'(1) && !active_q && rom_q == '0)
    else $error("clear did not restore search state");

  a_last_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_o.status == ST_FOUND_LAST |=> lds_q)
    else $error("last device not recorded");

  a_done_idles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res_o.done |=> !active_q)
    else $error("search still active after pass ended");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> pos_q >= POS_W'(1) && pos_q < BIT_END)
    else $error("bit position out of range during search");

endmodule

`default_nettype wire

[hw/rtl/onewire_rom_search.sv]
// Top level of the 1-Wire ROM search engine.
`timescale 1ns / 1ps
`default_nettype none

// 1-Wire search ROM engine. Words enter through push/full: begin (with the
// presence result), id bit pair, or clear. Every word yields exactly one result
// word on the output queue (empty/pop) carrying status, the direction bit to
// drive on the bus, the pass-done flag, the ROM code built so far and the last
// family discrepancy. A command queue feeds a combinational search step, whose
// results go into a result queue, so the block sustains one word per clock
// while the result queue is not full; the word is held in the command queue
// and its result in the result queue before it reaches the output ports. The
// search step (direction choice, ROM bit write, CRC-8 update, end-of-pass
// check) sets that rate. Queue depths are set by CmdDepth and ResDepth.
module onewire_rom_search #(
  parameter int unsigned CmdDepth = ows_pkg::CMD_DEPTH,
  parameter int unsigned ResDepth = ows_pkg::RES_DEPTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [1:0]                cmd_i,
  input  wire logic                      presence_ok_i,
  input  wire logic                      id_bit_i,
  input  wire logic                      complement_bit_i,
  output logic                           empty,
  input  wire logic                      pop,
  output logic [1:0]                     status_o,
  output logic                           direction_o,
  output logic                           done_res_o,
  output logic [ows_pkg::ROM_W-1:0]      rom_code_o,
  output logic [ows_pkg::FAM_W-1:0]      family_discrepancy_o
);

  import ows_pkg::*;

  cmd_word_t cmd_word;
  logic      cmd_valid;
  logic      cmd_take;
  result_t   res_in;
  result_t   res_out;
  logic      res_push;
  logic      res_full;

  ows_front #(
    .Depth (CmdDepth)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .cmd_i            (cmd_i),
    .presence_ok_i    (presence_ok_i),
    .id_bit_i         (id_bit_i),
    .complement_bit_i (complement_bit_i),
    .word_o           (cmd_word),
    .valid_o          (cmd_valid),
    .take_i           (cmd_take)
  );

  ows_engine u_engine (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .word_i     (cmd_word),
    .valid_i    (cmd_valid),
    .take_o     (cmd_take),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  ows_fifo #(
    .Width ($bits(result_t)),
    .Depth (ResDepth)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_out),
    .empty_o (empty)
  );

  assign status_o             = res_out.status;
  assign direction_o          = res_out.direction;
  assign done_res_o           = res_out.done;
  assign rom_code_o           = res_out.rom_code;
  assign family_discrepancy_o = res_out.family_disc;

endmodule

`default_nettype wire

[dv/onewire_rom_search_tb.sv]
// Testbench for the 1-Wire ROM search engine: directed words and simulated device buses.
`timescale 1ns / 1ps
module onewire_rom_search_tb;
  import ows_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 120;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned WORD_TARGET  = 1400;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned MAX_DEVICES  = 6;
  localparam logic [CRC_W-1:0] CRC_REFL = {1'b1, CRC_TAP[CRC_W-1:1]};

  typedef enum int {
    DEV_GOOD,
    DEV_BAD_CRC,
    DEV_ZERO_FAMILY
  } dev_kind_e;

  typedef struct {
    status_e          status;
    logic             direction;
    logic             done;
    logic [ROM_W-1:0] rom_code;
    logic [FAM_W-1:0] family;
  } search_result_t;

  logic                 clk_i                = 1'b0;
  logic                 rst_ni               = 1'b0;
  logic                 push                 = 1'b0;
  logic                 full;
  logic [1:0]           cmd_i                = CMD_CLEAR;
  logic                 presence_ok_i        = 1'b0;
  logic                 id_bit_i             = 1'b0;
  logic                 complement_bit_i     = 1'b0;
  logic                 empty;
  logic                 pop                  = 1'b0;
  logic [1:0]           status_o;
  logic                 direction_o;
  logic                 done_res_o;
  logic [ROM_W-1:0]     rom_code_o;
  logic [FAM_W-1:0]     family_discrepancy_o;

  logic [ROM_W-1:0] rom_q;
  logic [POS_W-1:0] last_disc_q;
  logic [FAM_W-1:0] fam_q;
  logic             last_dev_q;
  logic [POS_W-1:0] pos_q;
  logic [POS_W-1:0] zero_pos_q;
  logic [CRC_W-1:0] crc_q;
  logic             active_q;

  search_result_t   pending_results[$];
  logic [ROM_W-1:0] dev_rom[MAX_DEVICES];
  bit               dev_alive[MAX_DEVICES];
  int               dev_count   = 0;
  int               errors      = 0;
  int               words_sent  = 0;
  int               idle_cycles = 0;
  bit               tx_idle_on  = 1'b1;
  bit               rx_idle_on  = 1'b1;
  bit               hold_req    = 1'b0;

  onewire_rom_search uut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .push                (push),
    .full                (full),
    .cmd_i               (cmd_i),
    .presence_ok_i       (presence_ok_i),
    .id_bit_i            (id_bit_i),
    .complement_bit_i    (complement_bit_i),
    .empty               (empty),
    .pop                 (pop),
    .status_o            (status_o),
    .direction_o         (direction_o),
    .done_res_o          (done_res_o),
    .rom_code_o          (rom_code_o),
    .family_discrepancy_o(family_discrepancy_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic void clear_history();
    last_disc_q = '0;
    last_dev_q  = 1'b0;
    fam_q       = '0;
  endfunction

  function automatic void reset_search();
    rom_q = '0;
    clear_history();
    pos_q      = POS_W'(1);
    zero_pos_q = '0;
    crc_q      = '0;
    active_q   = 1'b0;
  endfunction

  function automatic search_result_t search_step(logic [1:0] cmd, logic pres, logic idb,
                                                 logic cmpb);
    search_result_t   r;
    logic [POS_W-1:0] pos;
    logic [5:0]       idx;
    logic             fb;
    r.status    = ST_CONTINUE;
    r.direction = 1'b0;
    r.done      = 1'b0;
    case (cmd)
      CMD_BEGIN: begin
        if (last_dev_q || !pres) begin
          clear_history();
          active_q = 1'b0;
          r.status = ST_NOT_FOUND;
          r.done   = 1'b1;
        end else begin
          pos_q      = POS_W'(1);
          zero_pos_q = '0;
          crc_q      = '0;
          active_q   = 1'b1;
        end
      end
      CMD_PAIR: begin
        if (!active_q) begin
          r.status = ST_NOT_FOUND;
          r.done   = 1'b1;
        end else if (idb && cmpb) begin
          clear_history();
          active_q = 1'b0;
          r.status = ST_NOT_FOUND;
          r.done   = 1'b1;
        end else begin
          pos = pos_q;
          idx = 6'(pos - POS_W'(1));
          if (idb != cmpb) begin
            r.direction = idb;
          end else begin
            if (pos < last_disc_q) r.direction = rom_q[idx];
            else r.direction = (pos == last_disc_q);
            if (!r.direction) begin
              zero_pos_q = pos;
              if (pos < FAMILY_LIMIT) fam_q = FAM_W'(pos);
            end
          end
          rom_q[idx] = r.direction;
          fb    = crc_q[0] ^ r.direction;
          crc_q = (crc_q >> 1) ^ ({CRC_W{fb}} & CRC_REFL);
          pos_q = pos + POS_W'(1);
          if (pos_q >= BIT_END) begin
            active_q = 1'b0;
            r.done   = 1'b1;
            if (crc_q == '0 && rom_q[7:0] != 8'h00) begin
              last_disc_q = zero_pos_q;
              if (last_disc_q == '0) begin
                last_dev_q = 1'b1;
                r.status   = ST_FOUND_LAST;
              end else begin
                r.status = ST_FOUND;
              end
            end else begin
              clear_history();
              r.status = ST_NOT_FOUND;
            end
          end
        end
      end
      CMD_CLEAR: begin
        reset_search();
        r.status = ST_NOT_FOUND;
        r.done   = 1'b1;
      end
      default: ;
    endcase
    r.rom_code = rom_q;
    r.family   = fam_q;
    return r;
  endfunction

  function automatic logic [ROM_W-1:0] make_device(bit related, dev_kind_e kind);
    logic [55:0]      body;
    logic [CRC_W-1:0] c;
    logic [ROM_W-1:0] peer;
    logic             fb;
    int               keep;
    body = 56'({$urandom(), $urandom()});
    if (related && dev_count > 0) begin
      peer = dev_rom[$urandom_range(0, dev_count - 1)];
      keep = $urandom_range(1, 55);
      for (int i = 0; i < keep; i++) body[i] = peer[i];
    end
    if (kind == DEV_ZERO_FAMILY) body[7:0] = 8'h00;
    else if (body[7:0] == 8'h00) body[$urandom_range(0, 7)] = 1'b1;
    c = '0;
    for (int i = 0; i < 56; i++) begin
      fb = c[0] ^ body[i];
      c  = (c >> 1) ^ ({CRC_W{fb}} & CRC_REFL);
    end
    if (kind == DEV_BAD_CRC) c[$urandom_range(0, 7)] ^= 1'b1;
    return {c, body};
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic pres, input logic idb,
                           input logic cmpb, output search_result_t r);
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      @(negedge clk_i);
      push <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end else begin
      @(negedge clk_i);
    end
    push             <= 1'b1;
    cmd_i            <= cmd;
    presence_ok_i    <= pres;
    id_bit_i         <= idb;
    complement_bit_i <= cmpb;
    r = search_step(cmd, pres, idb, cmpb);
    pending_results.push_back(r);
    words_sent++;
    do @(posedge clk_i); while (full);
  endtask

  task automatic send_begin(input logic pres);
    search_result_t r;
    send_word(CMD_BEGIN, pres, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r);
  endtask

  task automatic send_pair(input logic idb, input logic cmpb);
    search_result_t r;
    send_word(CMD_PAIR, 1'($urandom_range(0, 1)), idb, cmpb, r);
  endtask

  task automatic send_clear();
    search_result_t r;
    send_word(CMD_CLEAR, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), r);
  endtask

  task automatic send_noise(input int n);
    search_result_t r;
    for (int i = 0; i < n; i++) begin
      send_word(2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r);
    end
  endtask

  task automatic go_idle();
    @(negedge clk_i);
    push <= 1'b0;
  endtask

  task automatic load_devices(input int n, input int related_pct, input int flaw_pct);
    dev_kind_e kind;
    dev_count = 0;
    for (int i = 0; i < n; i++) begin
      kind = DEV_GOOD;
      if ($urandom_range(0, 99) < flaw_pct) begin
        kind = ($urandom_range(0, 1) == 0) ? DEV_BAD_CRC : DEV_ZERO_FAMILY;
      end
      dev_rom[i] = make_device($urandom_range(0, 99) < related_pct, kind);
      dev_count++;
    end
  endtask

  // Drive one bus pass: devices answer with wired-AND bits and drop out on a mismatch.
  task automatic run_pass(input int noise_pct, output status_e st);
    search_result_t r;
    logic           idb;
    logic           cmpb;
    send_word(CMD_BEGIN, dev_count > 0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), r);
    st = r.status;
    if (r.done) return;
    for (int i = 0; i < dev_count; i++) dev_alive[i] = 1'b1;
    for (int b = 0; b < ROM_W; b++) begin
      idb  = 1'b1;
      cmpb = 1'b1;
      for (int i = 0; i < dev_count; i++) begin
        if (dev_alive[i]) begin
          idb  &= dev_rom[i][b];
          cmpb &= ~dev_rom[i][b];
        end
      end
      if ($urandom_range(0, 99) < noise_pct) begin
        idb  = 1'($urandom_range(0, 1));
        cmpb = 1'($urandom_range(0, 1));
      end
      send_word(CMD_PAIR, 1'($urandom_range(0, 1)), idb, cmpb, r);
      for (int i = 0; i < dev_count; i++) begin
        if (dev_rom[i][b] != r.direction) dev_alive[i] = 1'b0;
      end
      st = r.status;
      if (r.done) return;
    end
  endtask

  task automatic enumerate(input int noise_pct);
    status_e st;
    for (int p = 0; p <= dev_count; p++) begin
      run_pass(noise_pct, st);
      if (st == ST_FOUND_LAST) break;
    end
    send_begin(dev_count > 0);
  endtask

  task automatic test_commands();
    send_pair(1'b1, 1'b0);
    send_pair(1'b1, 1'b1);
    send_clear();
    send_begin(1'b0);
    send_begin(1'b1);
    send_pair(1'b0, 1'b1);
    send_pair(1'b1, 1'b0);
    send_pair(1'b0, 1'b0);
    send_pair(1'b0, 1'b0);
    send_pair(1'b1, 1'b1);
    send_begin(1'b1);
    send_pair(1'b1, 1'b0);
    send_clear();
    send_pair(1'b0, 1'b0);
    send_begin(1'b1);
    send_begin(1'b0);
    send_pair(1'b0, 1'b1);
  endtask

  task automatic test_single_device();
    load_devices(1, 0, 0);
    enumerate(0);
  endtask

  task automatic test_failed_passes();
    dev_count  = 1;
    dev_rom[0] = make_device(1'b0, DEV_BAD_CRC);
    enumerate(0);
    dev_rom[0] = make_device(1'b0, DEV_ZERO_FAMILY);
    enumerate(0);
  endtask

  task automatic test_device_pairs();
    load_devices(2, 100, 0);
    enumerate(0);
    load_devices(3, 100, 0);
    enumerate(0);
  endtask

  task automatic test_back_pressure();
    hold_req   = 1'b1;
    tx_idle_on = 1'b0;
    send_noise(24);
    go_idle();
    wait (!hold_req);
    tx_idle_on = 1'b1;
  endtask

  task automatic test_random_searches();
    while (words_sent < WORD_TARGET - 300) begin
      if ($urandom_range(0, 4) == 0) begin
        send_noise($urandom_range(1, 12));
      end else begin
        load_devices($urandom_range(1, 5), 60, 10);
        enumerate(($urandom_range(0, 3) == 0) ? 2 : 0);
      end
    end
  endtask

  task automatic test_steady_tail();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    load_devices(2, 50, 0);
    enumerate(0);
    go_idle();
  endtask

  initial begin : drain_results
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        pop <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    search_result_t want;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing pending: status %0d", status_o);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          errors++;
        end
        if (direction_o !== want.direction) begin
          $error("direction: expected %0d, got %0d", want.direction, direction_o);
          errors++;
        end
        if (done_res_o !== want.done) begin
          $error("done_res: expected %0d, got %0d", want.done, done_res_o);
          errors++;
        end
        if (rom_code_o !== want.rom_code) begin
          $error("rom_code: expected %h, got %h", want.rom_code, rom_code_o);
          errors++;
        end
        if (family_discrepancy_o !== want.family) begin
          $error("family_discrepancy: expected %0d, got %0d", want.family,
                 family_discrepancy_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("onewire_rom_search_tb: errors");
      $finish;
    end
  end

  initial begin
    reset_search();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_commands();
    test_single_device();
    test_failed_passes();
    test_device_pairs();
    test_back_pressure();
    test_random_searches();
    test_steady_tail();
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("onewire_rom_search_tb: clean");
    end else begin
      $display("onewire_rom_search_tb: errors");
    end
    $finish;
  end

endmodule
